FILE: sv/wdmc_pkg.sv
// wdmc_pkg: item types, function and mode codes and register indexes
// for the dual watchdog match counter; no dependencies
`default_nettype none

package wdmc_pkg;

  localparam int MATCH_W = 16;
  localparam int OUT_W   = 16;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // input item functions
  localparam logic [2:0] FUNC_TICK       = 3'd0;
  localparam logic [2:0] FUNC_ENABLES    = 3'd1;
  localparam logic [2:0] FUNC_CLR_IRQ    = 3'd2;
  localparam logic [2:0] FUNC_CLR_CNT    = 3'd3;
  localparam logic [2:0] FUNC_STATUS     = 3'd4;
  localparam logic [2:0] FUNC_READ_CAUSE = 3'd5;

  // match actions
  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_IRQ     = 2'd1;
  localparam logic [1:0] MODE_RST     = 2'd2;
  localparam logic [1:0] MODE_IRQ_RST = 2'd3;

  // unhandled count value at which the next match escalates
  localparam logic [1:0] UNH_LAST = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_MATCH0   = 3'd0;
  localparam logic [2:0] REG_MATCH1   = 3'd1;
  localparam logic [2:0] REG_MODE0    = 3'd2;
  localparam logic [2:0] REG_MODE1    = 3'd3;
  localparam logic [2:0] REG_CLR_ON0  = 3'd4;
  localparam logic [2:0] REG_CLR_ON1  = 3'd5;
  localparam logic [2:0] REG_CASCADE  = 3'd6;

  typedef struct packed {
    logic [2:0] func;
    logic [1:0] counter_mask;
    logic [1:0] enable_value;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] counter0_value;
    logic [OUT_W-1:0] counter1_value;
    logic [1:0]       interrupt_pending;
    logic [1:0]       enabled_status;
    logic             watchdog_reset;
    logic             reset_by_watchdog;
  } out_item_t;

  // per-counter settings
  typedef struct packed {
    logic [MATCH_W-1:0] match;
    logic [1:0]         mode;
    logic               clear_on_match;
  } cnt_cfg_t;

  // match action requested by one counter
  typedef struct packed {
    logic set_irq;
    logic wdt;
  } act_t;

endpackage

`default_nettype wire

FILE: sv/wdmc_counter.sv
// wdmc_counter: one watchdog counter with match detect, clear on match
// and unhandled-match escalation; uses wdmc_pkg
`default_nettype none

module wdmc_counter #(
  parameter int COUNTER_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    adv,
  input  wire logic                    clr_cnt,
  input  wire logic                    clr_irq,
  input  wire wdmc_pkg::cnt_cfg_t      cfg,
  output logic                         match,
  output logic [COUNTER_BITS-1:0]      count_nxt,
  output wdmc_pkg::act_t               act
);

  localparam int CMP_W = (COUNTER_BITS > wdmc_pkg::MATCH_W) ? COUNTER_BITS
                                                           : wdmc_pkg::MATCH_W;

  logic [COUNTER_BITS-1:0] count_r;
  logic [1:0]              unh_r, unh_nxt;

  assign match = adv && (CMP_W'(count_r) == CMP_W'(cfg.match));

  always_comb begin
    count_nxt = count_r;
    if (clr_cnt) begin
      count_nxt = '0;
    end else if (adv) begin
      count_nxt = (match && cfg.clear_on_match) ? '0 : count_r + 1'b1;
    end
  end

  always_comb begin
    act     = '0;
    unh_nxt = unh_r;
    if (clr_irq) begin
      unh_nxt = '0;
    end else if (match) begin
      unique case (cfg.mode)
        wdmc_pkg::MODE_IRQ: act.set_irq = 1'b1;
        wdmc_pkg::MODE_RST: act.wdt = 1'b1;
        wdmc_pkg::MODE_IRQ_RST: begin
          act.set_irq = 1'b1;
          if (unh_r == wdmc_pkg::UNH_LAST) begin
            act.wdt = 1'b1;
            unh_nxt = '0;
          end else begin
            unh_nxt = unh_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      unh_r   <= '0;
    end else begin
      count_r <= count_nxt;
      unh_r   <= unh_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/wdmc_cfg.sv
// wdmc_cfg: apb register file for match values, modes, clear on match
// and cascade; all but match writes are locked while a counter runs; uses wdmc_pkg
`default_nettype none

module wdmc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wdmc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [wdmc_pkg::DATA_W-1:0]   pwdata,
  output logic      [wdmc_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic [1:0]                    enable_flags,
  output wdmc_pkg::cnt_cfg_t                 cfg0,
  output wdmc_pkg::cnt_cfg_t                 cfg1,
  output logic                               cascade
);

  wdmc_pkg::cnt_cfg_t cfg0_r, cfg1_r;
  logic               cascade_r;
  logic               wr;
  logic [2:0]         idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign idx     = paddr[4:2];
  assign cfg0    = cfg0_r;
  assign cfg1    = cfg1_r;
  assign cascade = cascade_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg0_r    <= '0;
      cfg1_r    <= '0;
      cascade_r <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        wdmc_pkg::REG_MATCH0: cfg0_r.match <= pwdata[wdmc_pkg::MATCH_W-1:0];
        wdmc_pkg::REG_MATCH1: cfg1_r.match <= pwdata[wdmc_pkg::MATCH_W-1:0];
        wdmc_pkg::REG_MODE0:  if (!enable_flags[0]) cfg0_r.mode <= pwdata[1:0];
        wdmc_pkg::REG_MODE1:  if (!enable_flags[1]) cfg1_r.mode <= pwdata[1:0];
        wdmc_pkg::REG_CLR_ON0:
          if (!enable_flags[0]) cfg0_r.clear_on_match <= pwdata[0];
        wdmc_pkg::REG_CLR_ON1:
          if (!enable_flags[1]) cfg1_r.clear_on_match <= pwdata[0];
        wdmc_pkg::REG_CASCADE: if (enable_flags == 2'b00) cascade_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      wdmc_pkg::REG_MATCH0:  prdata = wdmc_pkg::DATA_W'(cfg0_r.match);
      wdmc_pkg::REG_MATCH1:  prdata = wdmc_pkg::DATA_W'(cfg1_r.match);
      wdmc_pkg::REG_MODE0:   prdata = wdmc_pkg::DATA_W'(cfg0_r.mode);
      wdmc_pkg::REG_MODE1:   prdata = wdmc_pkg::DATA_W'(cfg1_r.mode);
      wdmc_pkg::REG_CLR_ON0: prdata = wdmc_pkg::DATA_W'(cfg0_r.clear_on_match);
      wdmc_pkg::REG_CLR_ON1: prdata = wdmc_pkg::DATA_W'(cfg1_r.clear_on_match);
      wdmc_pkg::REG_CASCADE: prdata = wdmc_pkg::DATA_W'(cascade_r);
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/dual_watchdog_match_counter_unit.sv
// dual_watchdog_match_counter_unit: top level, item decode, interrupt and
// reset-cause flags and the result register; uses wdmc_pkg, wdmc_cfg, wdmc_counter
`default_nettype none

// Two watchdog counters advance on tick items while enabled. Each input item
// (tick, enable write, interrupt clear, counter reset, status read or
// reset-cause read and clear) is applied to the state in the cycle it is
// accepted and yields exactly one result item, which sits in a single output
// register. The block takes one item per cycle: in_stall rises only while a
// result is held in the output register and out_stall is high; results are
// registered, and a full-rate stream passes whenever the result side keeps up.
// On a tick a counter matches when it is advanced and its count before the
// tick equals its match value; it then clears (clear on match) or counts on, and
// its mode action is taken: none, interrupt, watchdog reset, or interrupt
// escalating to reset on the third match not handled by an interrupt clear.
// With cascade set counter one advances only on ticks where counter zero
// matched. A watchdog reset raises watchdog_reset in that result and sets the
// sticky cause; counters and settings are kept. Mode, clear on match and
// cascade writes are ignored while the affected counter (any counter, for
// cascade) is enabled. Registers sit at byte addresses 0, 4, ... 24 (low two
// address bits ignored); writes at 28 are dropped and reads there return zero.
// Result counter values are the low 16 bits of the COUNTER_BITS wide counts.
module dual_watchdog_match_counter_unit #(
  parameter int COUNTER_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire wdmc_pkg::in_item_t            in_data,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output wdmc_pkg::out_item_t                out_data,
  // register port
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [wdmc_pkg::ADDR_W-1:0]   cfg_paddr,
  input  wire logic [wdmc_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic      [wdmc_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);

  // settings
  wdmc_pkg::cnt_cfg_t cfg0, cfg1;
  logic               cascade;

  // status flags
  logic [1:0] pending_r, pending_nxt;
  logic [1:0] enable_r, enable_nxt;
  logic       cause_r, cause_nxt, cause_out;

  // result register
  wdmc_pkg::out_item_t out_r, out_nxt;
  logic                out_valid_r;

  // item decode
  logic       in_acc;
  logic       is_tick, is_clr_irq, is_clr_cnt;
  logic       adv0, adv1, m0, m1, wdt;
  logic [COUNTER_BITS-1:0] cnt0_nxt, cnt1_nxt;
  wdmc_pkg::act_t act0, act1;

  // previous counts, registered from the counters' next values
  logic [COUNTER_BITS-1:0] u_cnt0_count_hold, u_cnt1_count_hold;
  logic [COUNTER_BITS-1:0] cnt0_hold_r, cnt1_hold_r;

  // result register frees up when it is empty or being taken
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign is_tick    = in_acc && (in_data.func == wdmc_pkg::FUNC_TICK);
  assign is_clr_irq = in_acc && (in_data.func == wdmc_pkg::FUNC_CLR_IRQ);
  assign is_clr_cnt = in_acc && (in_data.func == wdmc_pkg::FUNC_CLR_CNT);

  // cascade gates counter one on counter zero's match in the same tick
  assign adv0 = is_tick && enable_r[0];
  assign adv1 = is_tick && enable_r[1] && (!cascade || m0);

  wdmc_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .enable_flags (enable_r),
    .cfg0         (cfg0),
    .cfg1         (cfg1),
    .cascade      (cascade)
  );

  wdmc_counter #(.COUNTER_BITS(COUNTER_BITS)) u_cnt0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv0),
    .clr_cnt   (is_clr_cnt && in_data.counter_mask[0]),
    .clr_irq   (is_clr_irq && in_data.counter_mask[0]),
    .cfg       (cfg0),
    .match     (m0),
    .count_nxt (cnt0_nxt),
    .act       (act0)
  );

  wdmc_counter #(.COUNTER_BITS(COUNTER_BITS)) u_cnt1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv1),
    .clr_cnt   (is_clr_cnt && in_data.counter_mask[1]),
    .clr_irq   (is_clr_irq && in_data.counter_mask[1]),
    .cfg       (cfg1),
    .match     (m1),
    .count_nxt (cnt1_nxt),
    .act       (act1)
  );

  assign wdt = act0.wdt || act1.wdt;

  always_comb begin
    pending_nxt = pending_r;
    enable_nxt  = enable_r;
    cause_nxt   = cause_r;
    cause_out   = cause_r;
    if (in_acc) begin
      unique case (in_data.func)
        wdmc_pkg::FUNC_TICK: begin
          pending_nxt = pending_r | {act1.set_irq, act0.set_irq};
          cause_nxt   = cause_r || wdt;
          cause_out   = cause_nxt;
        end
        wdmc_pkg::FUNC_ENABLES: enable_nxt = in_data.enable_value;
        wdmc_pkg::FUNC_CLR_IRQ: pending_nxt = pending_r & ~in_data.counter_mask;
        // read returns the cause before it is cleared
        wdmc_pkg::FUNC_READ_CAUSE: cause_nxt = 1'b0;
        // counter reset is handled in the counters; others read status
        default: ;
      endcase
    end
  end

  always_comb begin
    out_nxt.counter0_value    = wdmc_pkg::OUT_W'(cnt0_nxt);
    out_nxt.counter1_value    = wdmc_pkg::OUT_W'(cnt1_nxt);
    out_nxt.interrupt_pending = pending_nxt;
    out_nxt.enabled_status    = enable_nxt;
    out_nxt.watchdog_reset    = is_tick && wdt;
    out_nxt.reset_by_watchdog = cause_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      enable_r    <= '0;
      cause_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      enable_r  <= enable_nxt;
      cause_r   <= cause_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt0_hold_r <= '0;
      cnt1_hold_r <= '0;
    end else begin
      cnt0_hold_r <= cnt0_nxt;
      cnt1_hold_r <= cnt1_nxt;
    end
  end

  assign u_cnt0_count_hold = cnt0_hold_r;
  assign u_cnt1_count_hold = cnt1_hold_r;

  // a reset asserted in a result always shows up in its sticky cause
  a_wdt_sets_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.watchdog_reset |-> out_r.reset_by_watchdog)
    else $error("watchdog reset reported without cause flag");

  // an enable write is reflected in its own result
  a_enable_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.func == wdmc_pkg::FUNC_ENABLES)
    |=> out_r.enabled_status == $past(in_data.enable_value))
    else $error("enabled status does not follow enable write");

  // a tick with both counters disabled leaves the counts alone
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    is_tick && (enable_r == 2'b00)
    |-> (cnt0_nxt == u_cnt0_count_hold) && (cnt1_nxt == u_cnt1_count_hold))
    else $error("disabled counter moved on a tick");

endmodule

`default_nettype wire

FILE: tb/dual_watchdog_match_counter_unit_tb.sv
// dual_watchdog_match_counter_unit_tb: self-checking bench for the dual watchdog
// match counter; depends on wdmc_pkg and dual_watchdog_match_counter_unit
`timescale 1ns / 100ps

module dual_watchdog_match_counter_unit_tb;

  // func codes with no function of their own, they read status
  localparam logic [2:0] FUNC_SPARE6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE7 = 3'd7;
  // register index past the last register, writes there are dropped
  localparam logic [2:0] REG_SPARE = 3'd7;

  localparam int RUN_TICKS  = 60;
  localparam int MAX_PRINTS = 40;

  // one row of the directed table: a register write or an item, where an
  // item may carry a hand-written expected status
  typedef struct packed {
    logic                is_reg;
    logic [2:0]          reg_idx;
    logic [31:0]         reg_val;
    wdmc_pkg::in_item_t  item;
    logic                typed;
    wdmc_pkg::out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  wdmc_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  wdmc_pkg::out_item_t out_data;

  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [wdmc_pkg::ADDR_W-1:0] paddr = '0;
  logic [wdmc_pkg::DATA_W-1:0] pwdata = '0;
  logic [wdmc_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  int src_idle_pct = 29;
  int snk_idle_pct = 79;
  int n_fail = 0;

  // status words the block owes us, oldest first
  wdmc_pkg::out_item_t predicted_status [$];
  dir_row_t            dir_rows [$];

  // predictor copy of the watchdog state and settings
  logic [15:0] wd_count [2];
  logic [15:0] wd_match [2];
  logic [1:0]  wd_mode [2];
  logic        wd_clr [2];
  logic [1:0]  wd_unh [2];
  logic [1:0]  wd_pend;
  logic [1:0]  wd_en;
  logic        wd_cascade;
  logic        wd_cause;

  dual_watchdog_match_counter_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (psel),
    .cfg_penable (penable),
    .cfg_pwrite  (pwrite),
    .cfg_paddr   (paddr),
    .cfg_pwdata  (pwdata),
    .cfg_prdata  (prdata),
    .cfg_pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side backpressure, rate set by the current idling phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < snk_idle_pct);
  end

  // hard stop in case the block hangs, several times the slowest good run
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_fail < MAX_PRINTS)
      $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
    n_fail++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  function automatic wdmc_pkg::in_item_t mk_item(input logic [2:0] func,
                                                 input logic [1:0] mask,
                                                 input logic [1:0] en);
    wdmc_pkg::in_item_t r;
    r.func = func;
    r.counter_mask = mask;
    r.enable_value = en;
    return r;
  endfunction

  // register write as the block applies it: mode, clear on match and
  // cascade are locked while the counter (any counter for cascade) runs
  function automatic void wd_write_reg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      wdmc_pkg::REG_MATCH0:  wd_match[0] = val[15:0];
      wdmc_pkg::REG_MATCH1:  wd_match[1] = val[15:0];
      wdmc_pkg::REG_MODE0:   if (!wd_en[0]) wd_mode[0] = val[1:0];
      wdmc_pkg::REG_MODE1:   if (!wd_en[1]) wd_mode[1] = val[1:0];
      wdmc_pkg::REG_CLR_ON0: if (!wd_en[0]) wd_clr[0] = val[0];
      wdmc_pkg::REG_CLR_ON1: if (!wd_en[1]) wd_clr[1] = val[0];
      wdmc_pkg::REG_CASCADE: if (wd_en == 2'b00) wd_cascade = val[0];
      default: ;
    endcase
  endfunction

  // one item through the watchdog, returns the status it should produce
  function automatic wdmc_pkg::out_item_t wd_step(input wdmc_pkg::in_item_t it);
    wdmc_pkg::out_item_t r;
    logic [1:0]          adv;
    logic [1:0]          hit;
    logic                fire;
    logic                cause_seen;
    fire = 1'b0;
    adv = 2'b00;
    hit = 2'b00;
    case (it.func)
      wdmc_pkg::FUNC_TICK: begin
        // match is judged on the count before the tick
        adv[0] = wd_en[0];
        hit[0] = adv[0] && (wd_count[0] == wd_match[0]);
        adv[1] = wd_en[1] && (!wd_cascade || hit[0]);
        hit[1] = adv[1] && (wd_count[1] == wd_match[1]);
        for (int k = 0; k < 2; k++) begin
          if (adv[k])
            wd_count[k] = (hit[k] && wd_clr[k]) ? 16'd0 : wd_count[k] + 16'd1;
          if (hit[k]) begin
            case (wd_mode[k])
              wdmc_pkg::MODE_IRQ: wd_pend[k] = 1'b1;
              wdmc_pkg::MODE_RST: fire = 1'b1;
              wdmc_pkg::MODE_IRQ_RST: begin
                // third match not handled by an interrupt clear escalates
                wd_pend[k] = 1'b1;
                if (wd_unh[k] == wdmc_pkg::UNH_LAST) begin
                  wd_unh[k] = 2'd0;
                  fire = 1'b1;
                end else begin
                  wd_unh[k] = wd_unh[k] + 2'd1;
                end
              end
              default: ;
            endcase
          end
        end
        if (fire) wd_cause = 1'b1;
      end
      wdmc_pkg::FUNC_ENABLES: wd_en = it.enable_value;
      wdmc_pkg::FUNC_CLR_IRQ: begin
        wd_pend = wd_pend & ~it.counter_mask;
        for (int k = 0; k < 2; k++)
          if (it.counter_mask[k]) wd_unh[k] = 2'd0;
      end
      wdmc_pkg::FUNC_CLR_CNT: begin
        for (int k = 0; k < 2; k++)
          if (it.counter_mask[k]) wd_count[k] = 16'd0;
      end
      default: ;
    endcase
    // the cause read returns the flag as it was, then clears it
    cause_seen = wd_cause;
    if (it.func == wdmc_pkg::FUNC_READ_CAUSE) wd_cause = 1'b0;
    r.counter0_value = wd_count[0];
    r.counter1_value = wd_count[1];
    r.interrupt_pending = wd_pend;
    r.enabled_status = wd_en;
    r.watchdog_reset = fire;
    r.reset_by_watchdog = cause_seen;
    return r;
  endfunction

  // mostly ticks so counters reach their match values, the rest bus items
  function automatic wdmc_pkg::in_item_t rand_item();
    int                 pick;
    wdmc_pkg::in_item_t r;
    pick = $urandom_range(0, 99);
    r = mk_item(wdmc_pkg::FUNC_TICK, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
    if (pick >= 55 && pick < 63) begin
      r.func = wdmc_pkg::FUNC_ENABLES;
      if ($urandom_range(0, 1) == 0) r.enable_value = 2'b11;
    end
    else if (pick >= 63 && pick < 75) r.func = wdmc_pkg::FUNC_CLR_IRQ;
    else if (pick >= 75 && pick < 83) r.func = wdmc_pkg::FUNC_CLR_CNT;
    else if (pick >= 83 && pick < 88) r.func = wdmc_pkg::FUNC_STATUS;
    else if (pick >= 88 && pick < 96) r.func = wdmc_pkg::FUNC_READ_CAUSE;
    else if (pick >= 96 && pick < 98) r.func = FUNC_SPARE6;
    else if (pick >= 98) r.func = FUNC_SPARE7;
    return r;
  endfunction

  // small match values so matches come often, now and then the extremes
  function automatic logic [31:0] rand_match();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0: v[15:0] = 16'hFFFF;
      1: v[15:0] = 16'h0000;
      2: ;
      default: v[15:0] = 16'($urandom_range(0, 5));
    endcase
    return v;
  endfunction

  // present one item, hold it until taken, then record what it should give
  task automatic send_item(input wdmc_pkg::in_item_t it, input logic typed,
                           input wdmc_pkg::out_item_t want);
    wdmc_pkg::out_item_t e;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    e = wd_step(it);
    if (typed) e = want;
    predicted_status.push_back(e);
  endtask

  // stop sending and wait for every outstanding status; one result per
  // item, so an empty queue means the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (predicted_status.size() != 0);
  endtask

  // setup phase, access phase until pready, then the bus goes idle
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    wd_write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic add_item(input logic [2:0] func, input logic [1:0] mask,
                          input logic [1:0] en, input logic typed,
                          input wdmc_pkg::out_item_t want);
    dir_row_t row;
    row = '0;
    row.item = mk_item(func, mask, en);
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  task automatic add_reg(input logic [2:0] idx, input logic [31:0] val);
    dir_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_rows.push_back(row);
  endtask

  // every accepted status against the oldest prediction
  always @(posedge clk) begin
    wdmc_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_status.size() == 0) begin
        report_mismatch("status with none expected", 32'(out_data.counter0_value), 32'd0);
      end else begin
        want = predicted_status.pop_front();
        check_field("counter0_value", 32'(out_data.counter0_value),
                    32'(want.counter0_value));
        check_field("counter1_value", 32'(out_data.counter1_value),
                    32'(want.counter1_value));
        check_field("interrupt_pending", 32'(out_data.interrupt_pending),
                    32'(want.interrupt_pending));
        check_field("enabled_status", 32'(out_data.enabled_status),
                    32'(want.enabled_status));
        check_field("watchdog_reset", 32'(out_data.watchdog_reset),
                    32'(want.watchdog_reset));
        check_field("reset_by_watchdog", 32'(out_data.reset_by_watchdog),
                    32'(want.reset_by_watchdog));
      end
    end
  end

  initial begin
    wdmc_pkg::out_item_t want;
    dir_row_t            row;
    logic [31:0]         v;
    int                  n;

    // predictor starts from the reset state, all zero
    for (int k = 0; k < 2; k++) begin
      wd_count[k] = 16'd0;
      wd_match[k] = 16'd0;
      wd_mode[k] = wdmc_pkg::MODE_NONE;
      wd_clr[k] = 1'b0;
      wd_unh[k] = 2'd0;
    end
    wd_pend = 2'b00;
    wd_en = 2'b00;
    wd_cascade = 1'b0;
    wd_cause = 1'b0;

    // directed table
    // straight out of reset everything reads zero, whatever the item
    want = '0;
    add_item(wdmc_pkg::FUNC_STATUS, 2'b11, 2'b11, 1'b1, want);
    add_item(FUNC_SPARE7, 2'b00, 2'b00, 1'b1, want);
    add_item(wdmc_pkg::FUNC_READ_CAUSE, 2'b00, 2'b00, 1'b1, want);
    add_item(wdmc_pkg::FUNC_TICK, 2'b11, 2'b11, 1'b1, want);   // disabled, nothing moves
    // counter zero escalates, counter one cascaded behind it
    add_reg(wdmc_pkg::REG_MATCH0, 32'hFFFF_0001);
    add_reg(wdmc_pkg::REG_MODE0, {30'h3FFF_FFFF, wdmc_pkg::MODE_IRQ_RST});
    add_reg(wdmc_pkg::REG_CLR_ON0, 32'd1);
    add_reg(wdmc_pkg::REG_MATCH1, 32'h0000_FFFF);
    add_reg(wdmc_pkg::REG_MODE1, {30'd0, wdmc_pkg::MODE_IRQ});
    add_reg(wdmc_pkg::REG_CLR_ON1, 32'd0);
    add_reg(wdmc_pkg::REG_CASCADE, 32'd1);
    add_reg(REG_SPARE, 32'hFFFF_FFFF);              // no register there
    want.enabled_status = 2'b11;
    add_item(wdmc_pkg::FUNC_ENABLES, 2'b00, 2'b11, 1'b1, want);
    // locked while running: these two must not take
    add_reg(wdmc_pkg::REG_MODE0, {30'd0, wdmc_pkg::MODE_NONE});
    add_reg(wdmc_pkg::REG_CASCADE, 32'd0);
    // six ticks: matches on every second one, the third raises the reset
    for (int k = 0; k < 6; k++) add_item(wdmc_pkg::FUNC_TICK, 2'b00, 2'b00, 1'b0, want);
    add_item(wdmc_pkg::FUNC_READ_CAUSE, 2'b11, 2'b00, 1'b0, want);   // returns the set flag
    add_item(wdmc_pkg::FUNC_READ_CAUSE, 2'b00, 2'b11, 1'b0, want);   // now cleared
    add_item(wdmc_pkg::FUNC_CLR_IRQ, 2'b01, 2'b00, 1'b0, want);
    add_item(wdmc_pkg::FUNC_CLR_IRQ, 2'b10, 2'b00, 1'b0, want);
    add_item(wdmc_pkg::FUNC_CLR_CNT, 2'b11, 2'b00, 1'b0, want);
    add_item(wdmc_pkg::FUNC_ENABLES, 2'b11, 2'b00, 1'b0, want);
    add_reg(wdmc_pkg::REG_MODE1, {30'd0, wdmc_pkg::MODE_RST});
    add_item(FUNC_SPARE6, 2'b11, 2'b11, 1'b0, want);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < dir_rows.size(); r++) begin
      row = dir_rows[r];
      if (row.is_reg) begin
        drain();
        reg_write(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.item, row.typed, row.want);
      end
    end

    // random phases: each one settles, rewrites every register and runs a
    // burst; idling goes sender-light, then receiver-light, then none
    for (int p = 0; p < 18; p++) begin
      if (p == 6) begin
        src_idle_pct = 79;
        snk_idle_pct = 29;
      end else if (p == 12) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      // usually stop the counters so the locked settings can change,
      // sometimes leave them running so the writes bounce
      if ($urandom_range(0, 4) != 0)
        send_item(mk_item(wdmc_pkg::FUNC_ENABLES, 2'($urandom_range(0, 3)), 2'b00),
                  1'b0, want);
      drain();
      reg_write(wdmc_pkg::REG_MATCH0, rand_match());
      reg_write(wdmc_pkg::REG_MATCH1, rand_match());
      reg_write(wdmc_pkg::REG_MODE0, $urandom());
      reg_write(wdmc_pkg::REG_MODE1, $urandom());
      reg_write(wdmc_pkg::REG_CLR_ON0, $urandom());
      reg_write(wdmc_pkg::REG_CLR_ON1, $urandom());
      reg_write(wdmc_pkg::REG_CASCADE, $urandom());
      if ($urandom_range(0, 3) == 0) reg_write(REG_SPARE, $urandom());
      v = $urandom();
      if ($urandom_range(0, 3) != 0) v[1:0] = 2'b11;
      send_item(mk_item(wdmc_pkg::FUNC_ENABLES, 2'($urandom_range(0, 3)), v[1:0]),
                1'b0, want);
      n = $urandom_range(65, 110);
      repeat (n) send_item(rand_item(), 1'b0, want);
    end

    // one run at full rate: counter zero runs free past its match value,
    // counter one only steps on that match and raises the reset there
    send_item(mk_item(wdmc_pkg::FUNC_ENABLES, 2'b00, 2'b00), 1'b0, want);
    drain();
    reg_write(wdmc_pkg::REG_MATCH0, 32'd5);
    reg_write(wdmc_pkg::REG_MODE0, {30'd0, wdmc_pkg::MODE_IRQ});
    reg_write(wdmc_pkg::REG_CLR_ON0, 32'd0);
    reg_write(wdmc_pkg::REG_MATCH1, 32'd0);
    reg_write(wdmc_pkg::REG_MODE1, {30'd0, wdmc_pkg::MODE_RST});
    reg_write(wdmc_pkg::REG_CLR_ON1, 32'd1);
    reg_write(wdmc_pkg::REG_CASCADE, 32'd1);
    send_item(mk_item(wdmc_pkg::FUNC_CLR_CNT, 2'b11, 2'b00), 1'b0, want);
    send_item(mk_item(wdmc_pkg::FUNC_ENABLES, 2'b00, 2'b11), 1'b0, want);
    repeat (RUN_TICKS) send_item(mk_item(wdmc_pkg::FUNC_TICK, 2'b00, 2'b00), 1'b0, want);
    send_item(mk_item(wdmc_pkg::FUNC_STATUS, 2'b00, 2'b00), 1'b0, want);
    send_item(mk_item(wdmc_pkg::FUNC_READ_CAUSE, 2'b00, 2'b00), 1'b0, want);

    // let the last status through, then watch for strays
    drain();
    repeat (4) @(posedge clk);
    if (predicted_status.size() != 0)
      report_mismatch("status never arrived", 32'(predicted_status.size()), 32'd0);
    if (n_fail == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: dual_watchdog_match_counter_unit.f
sv/wdmc_pkg.sv
sv/wdmc_counter.sv
sv/wdmc_cfg.sv
sv/dual_watchdog_match_counter_unit.sv
tb/dual_watchdog_match_counter_unit_tb.sv
